// ----- rtl/mpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Manchester packet transmitter package
// Shared payload types, register indexes, request codes and reset values.
// ----------------------------------------------------------------------------
package mpt_pkg;

   // Field widths of the request and response payloads.
   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 5;
   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BUSY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   // Configuration register indexes and the address layout.
   localparam int REG_IDX_W  = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [REG_IDX_W-1:0] REG_PREAMBLE_BIT = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_START_BIT    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_PREAMBLE_LEN = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_POSTAMBLE_LEN = 2'd3;

   // Configuration reset values.
   localparam logic               RST_PREAMBLE_BIT  = 1'b1;
   localparam logic               RST_START_BIT     = 1'b0;
   localparam logic [COUNT_W-1:0] RST_PREAMBLE_LEN  = 4'd4;
   localparam logic [COUNT_W-1:0] RST_POSTAMBLE_LEN = 4'd8;

   // Number of bits in one data byte.
   localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [INDEX_W-1:0]  byte_index;
      logic [BYTE_W-1:0]   byte_value;
      logic [LENGTH_W-1:0] packet_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                pin_enable;
      logic                pin_level;
      logic                packet_done;
   } rsp_type;

   typedef struct packed {
      logic               preamble_bit_value;
      logic               start_bit_value;
      logic [COUNT_W-1:0] preamble_length;
      logic [COUNT_W-1:0] postamble_length;
   } cfg_type;

endpackage

// ----- rtl/mpt_if.sv -----
// ----------------------------------------------------------------------------
// Manchester packet transmitter channel interfaces
// Valid/ready channels for requests and for responses.
// ----------------------------------------------------------------------------
interface mpt_req_if;
   logic                          valid;
   logic                          ready;
   logic [mpt_pkg::KIND_W-1:0]    kind;
   logic [mpt_pkg::INDEX_W-1:0]   byte_index;
   logic [mpt_pkg::BYTE_W-1:0]    byte_value;
   logic [mpt_pkg::LENGTH_W-1:0]  packet_length;

   modport source (output valid, kind, byte_index, byte_value, packet_length,
                   input ready);
   modport sink (input valid, kind, byte_index, byte_value, packet_length,
                 output ready);
endinterface

interface mpt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mpt_pkg::STATUS_W-1:0]  status;
   logic                          pin_enable;
   logic                          pin_level;
   logic                          packet_done;

   modport source (output valid, status, pin_enable, pin_level, packet_done,
                   input ready);
   modport sink (input valid, status, pin_enable, pin_level, packet_done,
                 output ready);
endinterface

// ----- rtl/mpt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array with a write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data is registered every cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mpt_csr.sv -----
// ----------------------------------------------------------------------------
// Manchester packet transmitter configuration registers
// APB-style register file holding the preamble and postamble settings.
// ----------------------------------------------------------------------------
module mpt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mpt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mpt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mpt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output mpt_pkg::cfg_type                 cfg
);

   logic                             preamble_bit_ff;
   logic                             start_bit_ff;
   logic [mpt_pkg::COUNT_W-1:0]      preamble_len_ff;
   logic [mpt_pkg::COUNT_W-1:0]      postamble_len_ff;
   logic                             wr_fire;
   logic [mpt_pkg::REG_IDX_W-1:0]    reg_idx;

   assign pready  = 1'b1;
   assign wr_fire = psel & penable & pwrite & pready;
   assign reg_idx = paddr[mpt_pkg::CSR_ADDR_W-1:2];

   // Register writes in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_bit_ff  <= mpt_pkg::RST_PREAMBLE_BIT;
         start_bit_ff     <= mpt_pkg::RST_START_BIT;
         preamble_len_ff  <= mpt_pkg::RST_PREAMBLE_LEN;
         postamble_len_ff <= mpt_pkg::RST_POSTAMBLE_LEN;
      end else if (wr_fire) begin
         unique case (reg_idx)
            mpt_pkg::REG_PREAMBLE_BIT: begin
               preamble_bit_ff <= pwdata[0];
            end
            mpt_pkg::REG_START_BIT: begin
               start_bit_ff <= pwdata[0];
            end
            mpt_pkg::REG_PREAMBLE_LEN: begin
               preamble_len_ff <= pwdata[mpt_pkg::COUNT_W-1:0];
            end
            mpt_pkg::REG_POSTAMBLE_LEN: begin
               postamble_len_ff <= pwdata[mpt_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         mpt_pkg::REG_PREAMBLE_BIT:  prdata = mpt_pkg::CSR_DATA_W'(preamble_bit_ff);
         mpt_pkg::REG_START_BIT:     prdata = mpt_pkg::CSR_DATA_W'(start_bit_ff);
         mpt_pkg::REG_PREAMBLE_LEN:  prdata = mpt_pkg::CSR_DATA_W'(preamble_len_ff);
         mpt_pkg::REG_POSTAMBLE_LEN: prdata = mpt_pkg::CSR_DATA_W'(postamble_len_ff);
         default:                    prdata = '0;
      endcase
   end

   assign cfg.preamble_bit_value = preamble_bit_ff;
   assign cfg.start_bit_value    = start_bit_ff;
   assign cfg.preamble_length    = preamble_len_ff;
   assign cfg.postamble_length   = postamble_len_ff;

endmodule

// ----- rtl/mpt_core.sv -----
// ----------------------------------------------------------------------------
// Manchester packet transmitter core
// Sequencer state and the update done for each request.
// ----------------------------------------------------------------------------
module mpt_core #(
   parameter int BUFFER_BYTES = 32,
   localparam int AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1,
   localparam int CNT_W = $clog2(BUFFER_BYTES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  mpt_pkg::req_type            req,
   input  mpt_pkg::cfg_type            cfg,
   input  logic [mpt_pkg::BYTE_W-1:0]  store_rd_data,
   output logic                        store_wr_en,
   output logic [AW-1:0]               store_wr_addr,
   output logic [mpt_pkg::BYTE_W-1:0]  store_wr_data,
   output logic [AW-1:0]               store_rd_addr,
   output mpt_pkg::rsp_type            rsp
);

   localparam logic [2:0] MODE_IDLE      = 3'd0;
   localparam logic [2:0] MODE_PREAMBLE  = 3'd1;
   localparam logic [2:0] MODE_START     = 3'd2;
   localparam logic [2:0] MODE_DATA      = 3'd3;
   localparam logic [2:0] MODE_POSTAMBLE = 3'd4;

   localparam logic [mpt_pkg::LENGTH_W-1:0] MAX_LEN = mpt_pkg::LENGTH_W'(BUFFER_BYTES);

   logic [2:0]                  mode_ff, mode_in;
   logic                        second_half_ff, second_half_in;
   logic                        next_level_ff, next_level_in;
   logic                        use_store_ff, use_store_in;
   logic [2:0]                  sel_bit_ff, sel_bit_in;
   logic                        line_driven_ff, line_driven_in;
   logic [mpt_pkg::COUNT_W-1:0] preamble_left_ff, preamble_left_in;
   logic [mpt_pkg::COUNT_W-1:0] postamble_left_ff, postamble_left_in;
   logic [CNT_W-1:0]            current_byte_ff, current_byte_in;
   logic [mpt_pkg::COUNT_W-1:0] current_bit_ff, current_bit_in;
   logic [CNT_W-1:0]            send_length_ff, send_length_in;

   logic                        busy;
   logic                        level_now;
   logic [mpt_pkg::COUNT_W-1:0] preamble_dec;
   logic [mpt_pkg::COUNT_W-1:0] postamble_dec;
   logic [mpt_pkg::COUNT_W-1:0] bit_inc;
   logic [CNT_W-1:0]            byte_inc;

   assign busy = (mode_ff != MODE_IDLE);

   // A data level is kept as a pointer into the buffer; the byte at
   // current_byte is read every cycle, so it is ready by the next tick.
   assign level_now     = use_store_ff ? store_rd_data[sel_bit_ff] : next_level_ff;
   assign preamble_dec  = preamble_left_ff - 1'b1;
   assign postamble_dec = postamble_left_ff - 1'b1;
   assign bit_inc       = current_bit_ff + 1'b1;
   assign byte_inc      = current_byte_ff + 1'b1;

   // Buffer port: writes come straight from the request, reads follow
   // the byte pointer's next value.
   assign store_wr_addr = AW'(req.byte_index);
   assign store_wr_data = req.byte_value;
   assign store_rd_addr = current_byte_in[AW-1:0];

   // Request decode and the half-bit sequencer.
   always_comb begin
      mode_in           = mode_ff;
      second_half_in    = second_half_ff;
      next_level_in     = next_level_ff;
      use_store_in      = use_store_ff;
      sel_bit_in        = sel_bit_ff;
      line_driven_in    = line_driven_ff;
      preamble_left_in  = preamble_left_ff;
      postamble_left_in = postamble_left_ff;
      current_byte_in   = current_byte_ff;
      current_bit_in    = current_bit_ff;
      send_length_in    = send_length_ff;
      store_wr_en       = 1'b0;
      rsp               = '0;

      if (fire) begin
         unique case (req.kind)
            mpt_pkg::KIND_WRITE: begin
               if (busy) begin
                  rsp.status = mpt_pkg::STATUS_BUSY;
               end else if (32'(req.byte_index) < BUFFER_BYTES) begin
                  store_wr_en = 1'b1;
               end
            end
            mpt_pkg::KIND_START: begin
               if (busy) begin
                  rsp.status = mpt_pkg::STATUS_BUSY;
               end else if (req.packet_length > MAX_LEN) begin
                  rsp.status = mpt_pkg::STATUS_TOO_LONG;
               end else begin
                  send_length_in   = CNT_W'(req.packet_length);
                  current_byte_in  = '0;
                  current_bit_in   = '0;
                  second_half_in   = 1'b0;
                  line_driven_in   = 1'b1;
                  next_level_in    = cfg.preamble_bit_value;
                  use_store_in     = 1'b0;
                  mode_in          = MODE_PREAMBLE;
                  preamble_left_in = cfg.preamble_length;
               end
            end
            mpt_pkg::KIND_TICK: begin
               rsp.pin_enable = line_driven_ff;
               rsp.pin_level  = line_driven_ff & level_now;
               if (!second_half_ff) begin
                  // First half of a bit: send the inverse next.
                  second_half_in = 1'b1;
                  next_level_in  = ~level_now;
                  use_store_in   = 1'b0;
               end else begin
                  unique case (mode_ff)
                     MODE_IDLE: begin
                        line_driven_in = 1'b0;
                        next_level_in  = 1'b0;
                        use_store_in   = 1'b0;
                     end
                     MODE_PREAMBLE: begin
                        second_half_in   = 1'b0;
                        preamble_left_in = preamble_dec;
                        use_store_in     = 1'b0;
                        if (preamble_dec == '0) begin
                           next_level_in = cfg.start_bit_value;
                           mode_in       = MODE_START;
                        end else begin
                           next_level_in = cfg.preamble_bit_value;
                        end
                     end
                     MODE_START: begin
                        // First data bit is bit 0 of byte 0.
                        second_half_in = 1'b0;
                        use_store_in   = 1'b1;
                        sel_bit_in     = '0;
                        mode_in        = MODE_DATA;
                     end
                     MODE_DATA: begin
                        second_half_in = 1'b0;
                        current_bit_in = bit_inc;
                        if (bit_inc < mpt_pkg::BITS_PER_BYTE) begin
                           use_store_in = 1'b1;
                           sel_bit_in   = bit_inc[2:0];
                        end else begin
                           current_byte_in = byte_inc;
                           if (byte_inc < send_length_ff) begin
                              current_bit_in = '0;
                              use_store_in   = 1'b1;
                              sel_bit_in     = '0;
                           end else begin
                              // Last byte sent: enter the low postamble.
                              mode_in           = MODE_POSTAMBLE;
                              postamble_left_in = cfg.postamble_length;
                              next_level_in     = 1'b0;
                              use_store_in      = 1'b0;
                              second_half_in    = 1'b1;
                           end
                        end
                     end
                     MODE_POSTAMBLE: begin
                        postamble_left_in = postamble_dec;
                        if (postamble_dec == 4'd1) begin
                           // Closing high spike.
                           second_half_in = 1'b0;
                           next_level_in  = 1'b1;
                           use_store_in   = 1'b0;
                        end else if (postamble_dec == '0) begin
                           mode_in         = MODE_IDLE;
                           rsp.packet_done = 1'b1;
                        end else begin
                           second_half_in = 1'b1;
                           next_level_in  = 1'b0;
                           use_store_in   = 1'b0;
                        end
                     end
                     default: begin
                        mode_in = MODE_IDLE;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_IDLE;
         second_half_ff    <= 1'b0;
         next_level_ff     <= 1'b0;
         use_store_ff      <= 1'b0;
         sel_bit_ff        <= '0;
         line_driven_ff    <= 1'b0;
         preamble_left_ff  <= '0;
         postamble_left_ff <= '0;
         current_byte_ff   <= '0;
         current_bit_ff    <= '0;
         send_length_ff    <= '0;
      end else begin
         mode_ff           <= mode_in;
         second_half_ff    <= second_half_in;
         next_level_ff     <= next_level_in;
         use_store_ff      <= use_store_in;
         sel_bit_ff        <= sel_bit_in;
         line_driven_ff    <= line_driven_in;
         preamble_left_ff  <= preamble_left_in;
         postamble_left_ff <= postamble_left_in;
         current_byte_ff   <= current_byte_in;
         current_bit_ff    <= current_bit_in;
         send_length_ff    <= send_length_in;
      end
   end

endmodule

// ----- rtl/mpt_skid.sv -----
// ----------------------------------------------------------------------------
// Manchester packet transmitter response buffer
// Two-entry output register that keeps requests flowing under backpressure.
// ----------------------------------------------------------------------------
module mpt_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mpt_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output mpt_pkg::rsp_type out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   mpt_pkg::rsp_type main_data_ff, main_data_in;
   mpt_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             pop;

   assign pop       = main_valid_ff & out_ready;
   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // Fill and drain of the main and skid entries.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   // Occupancy flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload holding registers.
   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ----- rtl/manchester_packet_transmitter.sv -----
// ----------------------------------------------------------------------------
// Manchester packet transmitter
// Top level: register file, packet buffer, sequencer and response buffer.
// ----------------------------------------------------------------------------
// Every request (buffer write, send start or half-bit tick) is decoded as it
// is accepted and its response is registered in the response buffer, so one
// request per clock is sustained while responses are taken. The packet buffer
// is a RAM with registered read; the byte being sent is read ahead every cycle,
// so a tick never waits for it. Backpressure on the response side is absorbed
// by a two-entry output buffer: requests are refused only while both entries
// hold responses. Each tick drives the level computed by the previous tick:
// preamble bits, a start bit, the data bytes LSB first in Manchester form,
// then a low postamble ending in a single high half-bit (none if its length
// is one); then packet_done is flagged and the next tick releases the pin.
module manchester_packet_transmitter #(
   parameter int BUFFER_BYTES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   mpt_req_if.sink                        req_chan,
   mpt_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mpt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mpt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mpt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

   mpt_pkg::cfg_type           cfg;
   mpt_pkg::req_type           req;
   mpt_pkg::rsp_type           core_rsp;
   mpt_pkg::rsp_type           out_rsp;
   logic                       fire;
   logic                       store_wr_en;
   logic [AW-1:0]              store_wr_addr;
   logic [mpt_pkg::BYTE_W-1:0] store_wr_data;
   logic [AW-1:0]              store_rd_addr;
   logic [mpt_pkg::BYTE_W-1:0] store_rd_data;

   // Request handshake and payload.
   assign fire              = req_chan.valid & req_chan.ready;
   assign req.kind          = req_chan.kind;
   assign req.byte_index    = req_chan.byte_index;
   assign req.byte_value    = req_chan.byte_value;
   assign req.packet_length = req_chan.packet_length;

   mpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   mpt_ram #(
      .WIDTH (mpt_pkg::BYTE_W),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   mpt_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .req           (req),
      .cfg           (cfg),
      .store_rd_data (store_rd_data),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_addr (store_rd_addr),
      .rsp           (core_rsp)
   );

   mpt_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fire),
      .in_ready  (req_chan.ready),
      .in_data   (core_rsp),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_rsp)
   );

   // Response payload.
   assign rsp_chan.status      = out_rsp.status;
   assign rsp_chan.pin_enable  = out_rsp.pin_enable;
   assign rsp_chan.pin_level   = out_rsp.pin_level;
   assign rsp_chan.packet_done = out_rsp.packet_done;

endmodule

// ----- rtl/mpt_checker.sv -----
// ----------------------------------------------------------------------------
// Manchester packet transmitter port checker
// Concurrent checks on the response port, bound to the top level.
// ----------------------------------------------------------------------------
module mpt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mpt_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_pin_enable,
   input logic                          rsp_pin_level,
   input logic                          rsp_packet_done
);

   // A stalled response stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_pin_enable) && $stable(rsp_pin_level)
         && $stable(rsp_packet_done))
      else $error("stalled response changed");

   // The response buffer is empty right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A finished packet is reported on a tick with the line still driven.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_done |->
         rsp_pin_enable && (rsp_status == mpt_pkg::STATUS_OK))
      else $error("packet done without driven line");

   // A high level is only shown while the line is driven.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pin_level |-> rsp_pin_enable)
      else $error("pin level high while released");

   // A refused request carries no line activity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != mpt_pkg::STATUS_OK) |->
         !rsp_pin_enable && !rsp_pin_level && !rsp_packet_done)
      else $error("refused request shows line activity");

endmodule

bind manchester_packet_transmitter mpt_checker u_mpt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_pin_enable  (rsp_chan.pin_enable),
   .rsp_pin_level   (rsp_chan.pin_level),
   .rsp_packet_done (rsp_chan.packet_done)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Manchester packet transmitter testbench
// Sends buffer writes, send starts and half-bit ticks through the request
// channel, predicts every response with an internal line model and compares
// each response field by field. Register settings change between phases
// while the transmitter is idle, and both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int BUFFER_BYTES   = 32;
   localparam int PHASE_ITEMS    = 40;
   localparam int LAST_PHASE     = 5;
   localparam int SQUEEZE_CYCLES = 90;
   localparam int WATCHDOG_LIMIT = 4000;

   // Request kind that the block does not decode.
   localparam logic [mpt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      TX_IDLE,
      TX_PREAMBLE,
      TX_START,
      TX_DATA,
      TX_POSTAMBLE
   } tx_state_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [mpt_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [mpt_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [mpt_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   mpt_req_if req_chan ();
   mpt_rsp_if rsp_chan ();

   manchester_packet_transmitter #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #10 clock = ~clock;

   // Line model state and the register settings it runs with.
   mpt_pkg::cfg_type line_cfg;
   tx_state_type     tx_state;
   logic             second_half;
   logic             next_level;
   logic             line_driven;
   logic [3:0]       preamble_left;
   logic [3:0]       postamble_left;
   logic [3:0]       bit_pos;
   logic [5:0]       byte_pos;
   logic [5:0]       send_len;
   logic [7:0]       packet_bytes [BUFFER_BYTES];

   mpt_pkg::req_type req_backlog [$];
   mpt_pkg::rsp_type awaited_line [$];
   mpt_pkg::req_type offered;
   mpt_pkg::rsp_type want;

   int  queued_total;
   int  requests_sent;
   int  responses_seen;
   int  packets_done;
   int  busy_refusals;
   int  long_refusals;
   int  settings_used;
   int  mismatches;
   int  req_gap;
   int  rsp_hold;
   int  stuck_cycles;
   bit  calm;
   bit  squeeze_due;

   // Works out the response to one request and advances the line model.
   function automatic mpt_pkg::rsp_type line_response(input mpt_pkg::req_type r);
      mpt_pkg::rsp_type o;
      logic             busy;
      o = '0;
      busy = (tx_state != TX_IDLE);
      case (r.kind)
         mpt_pkg::KIND_WRITE: begin
            if (busy) begin
               o.status = mpt_pkg::STATUS_BUSY;
            end else begin
               packet_bytes[r.byte_index] = r.byte_value;
            end
         end
         mpt_pkg::KIND_START: begin
            if (busy) begin
               o.status = mpt_pkg::STATUS_BUSY;
            end else if (r.packet_length > BUFFER_BYTES) begin
               o.status = mpt_pkg::STATUS_TOO_LONG;
            end else begin
               send_len = r.packet_length[5:0];
               byte_pos = '0;
               bit_pos = '0;
               second_half = 1'b0;
               line_driven = 1'b1;
               next_level = line_cfg.preamble_bit_value;
               tx_state = TX_PREAMBLE;
               preamble_left = line_cfg.preamble_length;
            end
         end
         mpt_pkg::KIND_TICK: begin
            o.pin_enable = line_driven;
            o.pin_level = line_driven & next_level;
            if (!second_half) begin
               // First half of a bit: the line flips to the inverse.
               second_half = 1'b1;
               next_level = ~next_level;
            end else begin
               case (tx_state)
                  TX_IDLE: begin
                     line_driven = 1'b0;
                     next_level = 1'b0;
                  end
                  TX_PREAMBLE: begin
                     second_half = 1'b0;
                     preamble_left = preamble_left - 4'd1;
                     if (preamble_left == 4'd0) begin
                        next_level = line_cfg.start_bit_value;
                        tx_state = TX_START;
                     end else begin
                        next_level = line_cfg.preamble_bit_value;
                     end
                  end
                  TX_START: begin
                     second_half = 1'b0;
                     next_level = packet_bytes[0][0];
                     tx_state = TX_DATA;
                  end
                  TX_DATA: begin
                     second_half = 1'b0;
                     bit_pos = bit_pos + 4'd1;
                     if (bit_pos < mpt_pkg::BITS_PER_BYTE) begin
                        next_level = packet_bytes[byte_pos[4:0]][bit_pos[2:0]];
                     end else begin
                        byte_pos = byte_pos + 6'd1;
                        if (byte_pos < send_len) begin
                           bit_pos = '0;
                           next_level = packet_bytes[byte_pos[4:0]][0];
                        end else begin
                           // Last data bit done: the postamble starts low.
                           tx_state = TX_POSTAMBLE;
                           postamble_left = line_cfg.postamble_length;
                           next_level = 1'b0;
                           second_half = 1'b1;
                        end
                     end
                  end
                  TX_POSTAMBLE: begin
                     postamble_left = postamble_left - 4'd1;
                     if (postamble_left == 4'd1) begin
                        second_half = 1'b0;
                        next_level = 1'b1;
                     end else if (postamble_left == 4'd0) begin
                        tx_state = TX_IDLE;
                        o.packet_done = 1'b1;
                     end else begin
                        second_half = 1'b1;
                        next_level = 1'b0;
                     end
                  end
                  default: tx_state = TX_IDLE;
               endcase
            end
         end
         default: ;
      endcase
      if (o.status == mpt_pkg::STATUS_BUSY) busy_refusals++;
      if (o.status == mpt_pkg::STATUS_TOO_LONG) long_refusals++;
      if (o.packet_done) packets_done++;
      return o;
   endfunction

   task automatic queue_req(input logic [mpt_pkg::KIND_W-1:0] kind, input int idx,
                            input int val, input int len);
      mpt_pkg::req_type item;
      item.kind = kind;
      item.byte_index = idx[mpt_pkg::INDEX_W-1:0];
      item.byte_value = val[mpt_pkg::BYTE_W-1:0];
      item.packet_length = len[mpt_pkg::LENGTH_W-1:0];
      req_backlog.push_back(item);
      queued_total++;
   endtask

   // One packet: a few buffer writes, a start and enough ticks to finish,
   // with stray requests mixed in and now and then a packet cut short.
   task automatic queue_packet(input int len);
      int ticks;
      int pre_bits;
      int post_ticks;
      repeat ($urandom_range(0, 3))
         queue_req(mpt_pkg::KIND_WRITE, $urandom_range(0, 31), $urandom_range(0, 255),
                   $urandom);
      if ($urandom_range(0, 5) == 0)
         queue_req(mpt_pkg::KIND_START, $urandom, $urandom,
                   $urandom_range(BUFFER_BYTES + 1, 255));
      queue_req(mpt_pkg::KIND_START, $urandom, $urandom, len);
      pre_bits = (line_cfg.preamble_length == 0) ? 16 : line_cfg.preamble_length;
      post_ticks = (line_cfg.postamble_length == 0) ? 17 : line_cfg.postamble_length + 1;
      ticks = 2 * pre_bits + 2 + 16 * ((len == 0) ? 1 : len) + post_ticks + 1
              + $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) ticks = $urandom_range(1, ticks / 2);
      repeat (ticks) begin
         case ($urandom_range(0, 15))
            0: queue_req(mpt_pkg::KIND_WRITE, $urandom, $urandom, $urandom);
            1: queue_req(mpt_pkg::KIND_START, $urandom, $urandom, $urandom_range(0, 255));
            2: queue_req(KIND_UNUSED, $urandom, $urandom, $urandom);
            default: ;
         endcase
         queue_req(mpt_pkg::KIND_TICK, $urandom, $urandom, $urandom);
      end
   endtask

   // Waits until every request has its response and the line is idle,
   // adding ticks while a packet is still on the line.
   task automatic settle();
      forever begin
         while (req_backlog.size() != 0 || req_chan.valid || awaited_line.size() != 0)
            @(negedge clock);
         if (tx_state == TX_IDLE) break;
         repeat (8) queue_req(mpt_pkg::KIND_TICK, $urandom, $urandom, $urandom);
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(input logic [mpt_pkg::REG_IDX_W-1:0] reg_idx,
                            input logic [mpt_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_config(input mpt_pkg::cfg_type c);
      csr_write(mpt_pkg::REG_PREAMBLE_BIT, mpt_pkg::CSR_DATA_W'(c.preamble_bit_value));
      csr_write(mpt_pkg::REG_START_BIT, mpt_pkg::CSR_DATA_W'(c.start_bit_value));
      csr_write(mpt_pkg::REG_PREAMBLE_LEN, mpt_pkg::CSR_DATA_W'(c.preamble_length));
      csr_write(mpt_pkg::REG_POSTAMBLE_LEN, mpt_pkg::CSR_DATA_W'(c.postamble_length));
      line_cfg = c;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [1:0] expected,
                              input logic [1:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatches++;
      end
   endtask

   // Request driver: holds a request until it is taken, with idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            awaited_line.push_back(line_response(offered));
            requests_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (req_backlog.size() != 0 && !calm && $urandom_range(0, 19) == 0) begin
               req_gap = $urandom_range(0, 13);
               req_chan.valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               offered = req_backlog.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.kind <= offered.kind;
               req_chan.byte_index <= offered.byte_index;
               req_chan.byte_value <= offered.byte_value;
               req_chan.packet_length <= offered.packet_length;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compares each response with the oldest prediction
   // and stalls the channel at random, once for a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            responses_seen++;
            if (awaited_line.size() == 0) begin
               $error("response with no request outstanding: status %0d, pin %0d/%0d",
                      rsp_chan.status, rsp_chan.pin_enable, rsp_chan.pin_level);
               mismatches++;
            end else begin
               want = awaited_line.pop_front();
               check_field("status", want.status, rsp_chan.status);
               check_field("pin_enable", want.pin_enable, rsp_chan.pin_enable);
               check_field("pin_level", want.pin_level, rsp_chan.pin_level);
               check_field("packet_done", want.packet_done, rsp_chan.packet_done);
            end
         end
         if (squeeze_due) begin
            squeeze_due = 1'b0;
            rsp_hold = SQUEEZE_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 19) == 0) begin
            rsp_hold = $urandom_range(0, 13);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake on either channel for %0d cycles", stuck_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      mpt_pkg::cfg_type next_cfg;
      int               phase;
      int               phase_start;
      int               len_pick;
      bit               last_phase;

      // Known levels on every input from time zero.
      req_chan.valid = 1'b0;
      req_chan.kind = mpt_pkg::KIND_WRITE;
      req_chan.byte_index = '0;
      req_chan.byte_value = '0;
      req_chan.packet_length = '0;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      // Line model after reset.
      line_cfg = '{mpt_pkg::RST_PREAMBLE_BIT, mpt_pkg::RST_START_BIT,
                   mpt_pkg::RST_PREAMBLE_LEN, mpt_pkg::RST_POSTAMBLE_LEN};
      tx_state = TX_IDLE;
      second_half = 1'b0;
      next_level = 1'b0;
      line_driven = 1'b0;
      preamble_left = '0;
      postamble_left = '0;
      bit_pos = '0;
      byte_pos = '0;
      send_len = '0;
      foreach (packet_bytes[i]) packet_bytes[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_config(line_cfg);

      // Fill the whole buffer so that no send reads a byte never written.
      for (int i = 0; i < BUFFER_BYTES; i++)
         queue_req(mpt_pkg::KIND_WRITE, i, $urandom_range(0, 255), $urandom);

      // Directed requests: idle tick, unused kind, refused starts, a
      // zero-length send with refused requests while it runs.
      queue_req(mpt_pkg::KIND_TICK, 0, 0, 0);
      queue_req(KIND_UNUSED, 31, 255, 255);
      queue_req(mpt_pkg::KIND_START, 0, 0, 255);
      queue_req(mpt_pkg::KIND_START, 31, 255, BUFFER_BYTES + 1);
      queue_req(mpt_pkg::KIND_WRITE, 0, 255, 0);
      queue_req(mpt_pkg::KIND_WRITE, 31, 0, 255);
      queue_req(mpt_pkg::KIND_START, 0, 0, 0);
      queue_req(mpt_pkg::KIND_WRITE, 1, 8'h5A, 0);
      queue_req(mpt_pkg::KIND_START, 0, 0, BUFFER_BYTES);
      queue_req(KIND_UNUSED, 0, 0, 0);
      repeat (39) queue_req(mpt_pkg::KIND_TICK, $urandom, $urandom, $urandom);
      settle();

      // Random packets under changing settings; the last phase runs with
      // no idling on either channel.
      phase = 1;
      last_phase = 1'b0;
      while (!last_phase) begin
         settle();
         last_phase = (phase >= LAST_PHASE);
         calm = last_phase;
         case (phase)
            1: next_cfg = '{1'b0, 1'b1, 4'd1, 4'd2};
            2: next_cfg = '{1'b1, 1'b0, 4'd15, 4'd15};
            3: next_cfg = '{1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 4'd0, 4'd1};
            4: next_cfg = '{1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 4'd2, 4'd0};
            default: next_cfg = '{1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
         endcase
         write_config(next_cfg);
         phase_start = queued_total;
         while (queued_total - phase_start < PHASE_ITEMS) begin
            len_pick = $urandom_range(0, 19);
            queue_packet(len_pick < 14 ? $urandom_range(0, 3) :
                         len_pick < 19 ? $urandom_range(4, 12) :
                         $urandom_range(13, BUFFER_BYTES));
         end
         // Long response stall while the sender keeps offering requests.
         if (phase == 2) squeeze_due = 1'b1;
         phase++;
      end
      settle();
      repeat (4) @(posedge clock);

      if (awaited_line.size() != 0) begin
         $error("%0d responses never arrived", awaited_line.size());
         mismatches++;
      end
      $display("Sent %0d requests under %0d register settings; %0d packets reached done.",
               requests_sent, settings_used, packets_done);
      $display("Refused requests: %0d while busy, %0d with a length over the buffer.",
               busy_refusals, long_refusals);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- manchester_packet_transmitter.f -----
rtl/mpt_pkg.sv
rtl/mpt_if.sv
rtl/mpt_ram.sv
rtl/mpt_csr.sv
rtl/mpt_core.sv
rtl/mpt_skid.sv
rtl/manchester_packet_transmitter.sv
rtl/mpt_checker.sv
dv/testbench.sv
